FILE: rtl/core/sip_pkg.sv
// Shared widths and the cell payload type for the segment intersection block.
// No dependencies; every other file in rtl/core imports this package.
package sip_pkg;

    // Coordinate width actually used from each 32-bit field (range 8..32)
    localparam int CB      = 32;
    localparam int FIELD_W = 32;
    localparam int DW      = CB + 1;          // coordinate differences
    localparam int PW      = 2 * DW;          // cross products
    localparam int WW      = PW + 1;          // den, A, B
    localparam int RW      = 2 * CB + 3;      // divider remainder and operands
    localparam int QW      = CB;              // quotient of one axis
    localparam int NW      = CB + 2;          // rounded coordinate before narrowing
    localparam int IN_W    = 8 * FIELD_W;
    localparam int OUT_BITS = 1 + 2 * FIELD_W;
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int LAT     = 4 + QW + 2;

    // Data that walks down a chain of divider cells
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] den;
        logic [RW-1:0] ap;
        logic [QW-1:0] q;
        logic [QW-1:0] mag;
    } lane_t;

endpackage

FILE: rtl/core/sip_cell.sv
// One cell of the multiply-divide chain: folds one bit of |delta| times A into
// the remainder and retires one radix-2 digit (0..2). Depends on sip_pkg.
module sip_cell (
    input  logic           aclk,
    input  logic           en,
    input  sip_pkg::lane_t lane_in,
    output sip_pkg::lane_t lane_out
);
    import sip_pkg::*;

    logic [RW-1:0] t;
    logic [RW-1:0] den2;
    lane_t         lane_reg;
    lane_t         lane_next;

    always_comb begin
        t    = {lane_in.rem[RW-2:0], 1'b0} + (lane_in.mag[QW-1] ? lane_in.ap : '0);
        den2 = {lane_in.den[RW-2:0], 1'b0};
        lane_next     = lane_in;
        lane_next.mag = {lane_in.mag[QW-2:0], 1'b0};
        if (t >= den2) begin
            lane_next.rem = t - den2;
            lane_next.q   = {lane_in.q[QW-2:0], 1'b0} + QW'(2);
        end else if (t >= lane_in.den) begin
            lane_next.rem = t - lane_in.den;
            lane_next.q   = {lane_in.q[QW-2:0], 1'b1};
        end else begin
            lane_next.rem = t;
            lane_next.q   = {lane_in.q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: rtl/core/sip_lane.sv
// Chain of QW divider cells for one axis: floor(A'*|delta| / |den|) and remainder.
// Depends on sip_pkg and sip_cell.
module sip_lane (
    input  logic           aclk,
    input  logic           en,
    input  sip_pkg::lane_t lane_in,
    output sip_pkg::lane_t lane_out
);
    import sip_pkg::*;

    lane_t link [0:QW];

    assign link[0] = lane_in;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        sip_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .lane_in (link[k]),
            .lane_out(link[k+1])
        );
    end

    assign lane_out = link[QW];

endmodule

FILE: rtl/core/sip_round.sv
// Turns one axis quotient and remainder into round(start + A*delta/den),
// halves away from zero, over two register stages. Depends on sip_pkg.
module sip_round (
    input  logic                              aclk,
    input  logic                              en,
    input  sip_pkg::lane_t                    fin,
    input  logic                              neg,
    input  logic signed [sip_pkg::CB-1:0]     start,
    input  logic                              ok,
    output logic                              ok_out,
    output logic signed [sip_pkg::FIELD_W-1:0] res
);
    import sip_pkg::*;

    logic                 nz;
    logic signed [NW-1:0] qext;
    logic signed [NW-1:0] qs;
    logic signed [NW-1:0] n_next;
    logic [RW-1:0]        rr_next;
    logic signed [NW-1:0] n_reg;
    logic [RW-1:0]        rr_reg;
    logic [RW-1:0]        den_reg;
    logic                 ok1_reg;
    logic [RW:0]          rr2;
    logic                 up;
    logic signed [NW-1:0] rn;
    logic signed [FIELD_W-1:0] res_reg;
    logic                 ok2_reg;

    always_comb begin
        nz      = (fin.rem != '0);
        qext    = signed'({2'b00, fin.q});
        // floor of a negative quotient: negate and borrow when a remainder is left
        qs      = neg ? (-qext - NW'(nz)) : qext;
        n_next  = NW'(start) + qs;
        rr_next = (neg && nz) ? (fin.den - fin.rem) : fin.rem;
    end

    always_comb begin
        rr2 = {rr_reg, 1'b0};
        up  = n_reg[NW-1] ? (rr2 > {1'b0, den_reg}) : (rr2 >= {1'b0, den_reg});
        rn  = n_reg + NW'(up);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg   <= n_next;
            rr_reg  <= rr_next;
            den_reg <= fin.den;
            ok1_reg <= ok;
            res_reg <= ok1_reg ? FIELD_W'(rn) : '0;
            ok2_reg <= ok1_reg;
        end
    end

    assign res    = res_reg;
    assign ok_out = ok2_reg;

endmodule

FILE: rtl/core/segment_intersection_point.sv
// Segment intersection point: pipelined crossing test and rounded crossing point.
// Depends on sip_pkg, sip_lane, sip_cell and sip_round.
//
// Usage:
//   Input channel s_*: one item holds two segments (eight signed coordinates).
//   Only the low CB bits of each field are used, sign-extended.
//   Result channel m_*: one item per input item, in order: hit flag and the
//   crossing point rounded half away from zero; the point is zero on a miss.
//   Parallel, collinear and degenerate segments report no hit.
// Timing:
//   The pipeline is four front stages (deltas, cross products, den/A/B, span
//   test), one divider cell per quotient bit of each axis, and two rounding
//   stages. One item enters per cycle while the result channel is not stalled.
//   The divider chain is the long part: each cell folds one bit of |delta|
//   into the remainder and retires one quotient digit.
// Flow control:
//   The whole pipeline advances together; when the result register holds an
//   item the receiver has not taken, every stage holds and s_tready drops.
//   A stall therefore costs no items and no bubbles.
// Reset:
//   aresetn clears all stage valid bits and holds s_tready low; items in
//   flight are dropped.
module segment_intersection_point (
    input  logic                      aclk,
    input  logic                      aresetn,
    // fields from bit 0 up: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
    input  logic [sip_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // fields from bit 0 up: hit (1), point_x (32), point_y (32), zero pad
    output logic [sip_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready
);
    import sip_pkg::*;

    typedef struct packed {
        logic                 ok;
        logic                 negx;
        logic                 negy;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
    } side_t;

    logic pipe_en;
    logic [LAT-1:0] vld_reg;

    // unpacked coordinates
    logic signed [CB-1:0] sx, sy, ex, ey, tx, ty, ux, uy;

    // stage 1: deltas
    logic signed [DW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [CB-1:0] sx1_reg, sy1_reg;
    // stage 2: cross products
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DW-1:0] ax2_reg, ay2_reg;
    logic signed [CB-1:0] sx2_reg, sy2_reg;
    // stage 3: den, A, B
    logic signed [WW-1:0] den3_reg, a3_reg, b3_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg;
    logic signed [CB-1:0] sx3_reg, sy3_reg;
    // stage 4: span test and divider operands
    logic                 pos;
    logic                 span_a, span_b;
    logic [RW-1:0]        dmag_next, ap_next;
    logic [DW-1:0]        axm, aym;
    lane_t                lx4_reg, ly4_reg;
    side_t                side4_reg;
    side_t                side_next;
    side_t                sb_reg [0:QW-1];
    lane_t                lx_out, ly_out;
    logic                 okx, oky;
    logic signed [FIELD_W-1:0] px, py;

    assign m_tvalid = vld_reg[LAT-1];
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en && aresetn;

    always_comb begin
        sx = s_tdata[0*FIELD_W +: CB];
        sy = s_tdata[1*FIELD_W +: CB];
        ex = s_tdata[2*FIELD_W +: CB];
        ey = s_tdata[3*FIELD_W +: CB];
        tx = s_tdata[4*FIELD_W +: CB];
        ty = s_tdata[5*FIELD_W +: CB];
        ux = s_tdata[6*FIELD_W +: CB];
        uy = s_tdata[7*FIELD_W +: CB];
    end

    // span test: A and B lie between 0 and den, inclusive, in den's direction
    always_comb begin
        pos    = !den3_reg[WW-1];
        span_a = pos ? (!a3_reg[WW-1] && (a3_reg <= den3_reg))
                     : ((a3_reg <= 0) && (a3_reg >= den3_reg));
        span_b = pos ? (!b3_reg[WW-1] && (b3_reg <= den3_reg))
                     : ((b3_reg <= 0) && (b3_reg >= den3_reg));
        dmag_next = RW'(pos ? den3_reg : -den3_reg);
        ap_next   = RW'(pos ? a3_reg : -a3_reg);
        axm       = ax3_reg[DW-1] ? DW'(-ax3_reg) : DW'(ax3_reg);
        aym       = ay3_reg[DW-1] ? DW'(-ay3_reg) : DW'(ay3_reg);
        side_next.ok   = (den3_reg != '0) && span_a && span_b;
        side_next.negx = ax3_reg[DW-1];
        side_next.negy = ay3_reg[DW-1];
        side_next.sx   = sx3_reg;
        side_next.sy   = sy3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ax1_reg <= DW'(ex) - DW'(sx);
            ay1_reg <= DW'(ey) - DW'(sy);
            bx1_reg <= DW'(tx) - DW'(ux);
            by1_reg <= DW'(ty) - DW'(uy);
            cx1_reg <= DW'(sx) - DW'(tx);
            cy1_reg <= DW'(sy) - DW'(ty);
            sx1_reg <= sx;
            sy1_reg <= sy;

            p0_reg  <= ay1_reg * bx1_reg;
            p1_reg  <= ax1_reg * by1_reg;
            p2_reg  <= by1_reg * cx1_reg;
            p3_reg  <= bx1_reg * cy1_reg;
            p4_reg  <= ax1_reg * cy1_reg;
            p5_reg  <= ay1_reg * cx1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;

            den3_reg <= WW'(p0_reg) - WW'(p1_reg);
            a3_reg   <= WW'(p2_reg) - WW'(p3_reg);
            b3_reg   <= WW'(p4_reg) - WW'(p5_reg);
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;

            lx4_reg.rem <= '0;
            lx4_reg.den <= dmag_next;
            lx4_reg.ap  <= ap_next;
            lx4_reg.q   <= '0;
            lx4_reg.mag <= axm[QW-1:0];
            ly4_reg.rem <= '0;
            ly4_reg.den <= dmag_next;
            ly4_reg.ap  <= ap_next;
            ly4_reg.q   <= '0;
            ly4_reg.mag <= aym[QW-1:0];
            side4_reg   <= side_next;

            // hold side data alongside the divider cells
            sb_reg[0] <= side4_reg;
            for (int k = 1; k < QW; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    sip_lane u_lane_x (
        .aclk    (aclk),
        .en      (pipe_en),
        .lane_in (lx4_reg),
        .lane_out(lx_out)
    );

    sip_lane u_lane_y (
        .aclk    (aclk),
        .en      (pipe_en),
        .lane_in (ly4_reg),
        .lane_out(ly_out)
    );

    sip_round u_round_x (
        .aclk  (aclk),
        .en    (pipe_en),
        .fin   (lx_out),
        .neg   (sb_reg[QW-1].negx),
        .start (sb_reg[QW-1].sx),
        .ok    (sb_reg[QW-1].ok),
        .ok_out(okx),
        .res   (px)
    );

    sip_round u_round_y (
        .aclk  (aclk),
        .en    (pipe_en),
        .fin   (ly_out),
        .neg   (sb_reg[QW-1].negy),
        .start (sb_reg[QW-1].sy),
        .ok    (sb_reg[QW-1].ok),
        .ok_out(oky),
        .res   (py)
    );

    assign m_tdata = OUT_W'({py, px, okx});

`ifndef ASSERT_OFF
    // both axes see the same hit decision
    a_hit_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (okx == oky))
        else $error("axis hit flags disagree");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !okx) |-> (px == '0 && py == '0))
        else $error("miss with nonzero point");

    // a stall freezes the stage valid bits
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved during stall");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item lost at entry");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for segment_intersection_point: directed table plus random pairs.
// Depends on sip_pkg and the segment_intersection_point RTL; predicts with wide integers.
`timescale 1ns / 1ps

module testbench;
    import sip_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [31:0] c [8];
        bit          known;   // expected result typed in
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
    } row_t;

    typedef struct {
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
    } crossing_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    crossing_t          pending_q[$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 send_idle = 0;   // percent of cycles the sender idles
    int                 recv_idle = 0;   // percent of cycles the receiver stalls

    segment_intersection_point u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // Sign-extend the used low CB bits of one coordinate.
    function automatic logic signed [127:0] coord(logic [31:0] v);
        logic signed [31:0] s;
        s = $signed(v << (32 - CB)) >>> (32 - CB);
        return 128'(s);
    endfunction

    // Round num/den to nearest, halves away from zero.
    function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic [127:0] n, d, q, r;
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q = q + 1;
        return (num[127] != den[127]) ? -$signed(q) : $signed(q);
    endfunction

    // Crossing test and crossing point for two segments.
    function automatic crossing_t predict_crossing(logic [31:0] c [8]);
        logic signed [127:0] sx, sy, ax, ay, bx, by, cx, cy, den, a, b;
        crossing_t res;
        bit ok_a, ok_b;
        sx = coord(c[0]); sy = coord(c[1]);
        ax = coord(c[2]) - sx; ay = coord(c[3]) - sy;
        bx = coord(c[4]) - coord(c[6]); by = coord(c[5]) - coord(c[7]);
        cx = sx - coord(c[4]); cy = sy - coord(c[5]);
        den = ay * bx - ax * by;
        res = '{hit: 1'b0, px: '0, py: '0};
        if (den != 0) begin
            a = by * cx - bx * cy;
            b = ax * cy - ay * cx;
            if (den > 0) begin
                ok_a = (a >= 0) && (a <= den);
                ok_b = (b >= 0) && (b <= den);
            end else begin
                ok_a = (a <= 0) && (a >= den);
                ok_b = (b <= 0) && (b >= den);
            end
            if (ok_a && ok_b) begin
                res.hit = 1'b1;
                res.px = 32'(round_div(sx * den + a * ax, den));
                res.py = 32'(round_div(sy * den + a * ay, den));
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        errors++;
    endtask

    // Drive one item at the falling edge and hold it until accepted.
    // Valid stays high after acceptance; drop it only when the sender idles.
    task automatic send_pair(row_t r);
        crossing_t e;
        bit        idle;
        idle = send_idle > 0 && $urandom_range(99) < send_idle;
        if (idle) s_tvalid <= 1'b0;
        while (idle) begin
            @(negedge aclk);
            idle = send_idle > 0 && $urandom_range(99) < send_idle;
        end
        for (int i = 0; i < 8; i++) s_tdata[32*i +: 32] = r.c[i];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e = predict_crossing(r.c);
        if (r.known) begin
            // typed-in rows check the predictor too
            if (e.hit !== r.hit || e.px !== r.px || e.py !== r.py) begin
                $display("typed-in row disagrees with predictor at cycle %0d", cycles);
                errors++;
            end
            e = '{hit: r.hit, px: r.px, py: r.py};
        end
        pending_q.push_back(e);
        @(negedge aclk);
    endtask

    // Random coordinate: mostly small, sometimes extreme or full width.
    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(9);
        if (k < 6) return 32'($signed($urandom_range(40)) - 20);
        if (k < 8) return $urandom();
        return (k == 8) ? 32'h7fffffff : 32'h80000000;
    endfunction

    function automatic row_t random_row();
        row_t r;
        int shape;
        r.known = 1'b0; r.hit = 1'b0; r.px = '0; r.py = '0;
        for (int i = 0; i < 8; i++) r.c[i] = rand_coord();
        shape = $urandom_range(9);
        // build crossing pairs: second segment spans a point on the first
        if (shape < 5) begin
            int span;
            span = (shape == 0) ? 1000000000 : 1000;
            for (int i = 0; i < 4; i++)
                r.c[i] = 32'($signed($urandom_range(2 * span)) - span);
            r.c[4] = 32'($signed(r.c[0]) + $signed(r.c[2])
                         - $signed(r.c[0]) + $signed($urandom_range(20)) - 10);
            r.c[5] = r.c[1];
            r.c[6] = r.c[0];
            r.c[7] = r.c[3];
        end else if (shape == 5) begin
            // parallel: same direction
            r.c[6] = 32'($signed(r.c[4]) + $signed(r.c[2]) - $signed(r.c[0]));
            r.c[7] = 32'($signed(r.c[5]) + $signed(r.c[3]) - $signed(r.c[1]));
        end
        return r;
    endfunction

    // Output side: random stall, sample at the rising edge, check in order.
    always @(negedge aclk)
        m_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            crossing_t e;
            if (pending_q.size() == 0) begin
                $display("unexpected result at cycle %0d", cycles);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[0] !== e.hit) report_mismatch("hit", 32'(m_tdata[0]), 32'(e.hit));
                if (m_tdata[32:1] !== e.px) report_mismatch("point_x", m_tdata[32:1], e.px);
                if (m_tdata[64:33] !== e.py) report_mismatch("point_y", m_tdata[64:33], e.py);
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Directed rows: x0..y3 as first start, first end, second start, second end.
    function automatic row_t mk(int c0, int c1, int c2, int c3, int c4, int c5, int c6,
                                int c7, bit kn, logic h, int x, int y);
        row_t r;
        r.c = '{c0, c1, c2, c3, c4, c5, c6, c7};
        r.known = kn; r.hit = h; r.px = x; r.py = y;
        return r;
    endfunction

    initial begin
        row_t table_rows[$];
        int   phase_send [4] = '{0, 51, 0, 13};
        int   phase_recv [4] = '{0, 0, 51, 13};
        int   max_i, min_i;
        max_i = 32'h7fffffff; min_i = 32'h80000000;
        // plain cross through origin
        table_rows.push_back(mk(-2, 0, 2, 0, 0, -2, 0, 2, 1, 1, 0, 0));
        // touching end points
        table_rows.push_back(mk(0, 0, 4, 4, 4, 4, 8, 0, 1, 1, 4, 4));
        // parallel, collinear, degenerate: no hit, point zero
        table_rows.push_back(mk(0, 0, 4, 0, 0, 1, 4, 1, 1, 0, 0, 0));
        table_rows.push_back(mk(0, 0, 4, 4, 1, 1, 6, 6, 1, 0, 0, 0));
        table_rows.push_back(mk(3, 3, 3, 3, 0, 0, 6, 6, 1, 0, 0, 0));
        table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        // disjoint, lines would cross
        table_rows.push_back(mk(0, 0, 1, 1, 5, 0, 4, 1, 1, 0, 0, 0));
        // half-way rounding cases, both signs
        table_rows.push_back(mk(0, 0, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(0, 0, -1, -1, 0, -1, -1, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0, 0));
        // extremes of the coordinate range, plus one degenerate all -1 pair
        table_rows.push_back(mk(min_i, min_i, max_i, max_i, min_i, max_i, max_i, min_i,
                                0, 0, 0, 0));
        table_rows.push_back(mk(max_i, min_i, min_i, max_i, min_i, min_i, max_i, max_i,
                                0, 0, 0, 0));
        table_rows.push_back(mk(min_i, 0, max_i, 0, 0, min_i, 0, max_i, 1, 1, 0, 0));
        table_rows.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0));
        table_rows.push_back(mk(max_i, max_i, max_i, min_i, min_i, max_i, max_i, max_i,
                                0, 0, 0, 0));
        table_rows.push_back(mk(min_i, min_i, min_i, max_i, min_i, min_i, max_i, min_i,
                                0, 0, 0, 0));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (table_rows[i]) send_pair(table_rows[i]);
        for (int p = 0; p < 4; p++) begin
            send_idle = phase_send[p];
            recv_idle = phase_recv[p];
            for (int n = 0; n < 310; n++) send_pair(random_row());
        end
        s_tvalid <= 1'b0;
        send_idle = 0;
        recv_idle = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
